>>> src/csa_pkg.sv
// Shared types, constants and helper functions for the call statistics accumulator.
package csa_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int SUM_WIDTH    = 64;
  localparam int COUNT_WIDTH  = 32;
  localparam int VALUE_WIDTH  = 64;

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SUM_WIDTH-1:0]    sum_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [VALUE_WIDTH-1:0]  value_t;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Statistic selectors for merge and read.
  typedef enum logic [3:0] {
    STAT_EVENT_COUNT   = 4'd0,
    STAT_DURATION_SUM  = 4'd1,
    STAT_DURATION_SQ   = 4'd2,
    STAT_DURATION_MAX  = 4'd3,
    STAT_DURATION_MIN  = 4'd4,
    STAT_SENT_SUM      = 4'd5,
    STAT_SENT_MAX      = 4'd6,
    STAT_SENT_MIN      = 4'd7,
    STAT_IO_SUM        = 4'd8,
    STAT_IO_MAX        = 4'd9,
    STAT_IO_MIN        = 4'd10,
    STAT_RMA_SUM       = 4'd11,
    STAT_LARGE_COUNT   = 4'd12
  } stat_idx_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_THRESHOLD_ENABLE = 1'b0,
    CFG_THRESHOLD_BYTES  = 1'b1
  } cfg_reg_t;

  // The full set of running statistics.
  typedef struct packed {
    count_t  event_count;
    sum_t    duration_sum;
    sum_t    duration_square_sum;
    sample_t duration_max;
    sample_t duration_min;
    sum_t    sent_sum;
    sample_t sent_max;
    sample_t sent_min;
    sum_t    io_sum;
    sample_t io_max;
    sample_t io_min;
    sum_t    rma_sum;
    count_t  large_message_count;
  } stats_t;

  // One registered item as it enters the update stage.
  typedef struct packed {
    cmd_t       command;
    sample_t    duration;
    sample_t    send_size;
    sample_t    io_size;
    sample_t    rma_size;
    sum_t       duration_square;
    stat_idx_t  stat_index;
    value_t     stat_value;
  } op_t;

  // Cleared statistics: minimums at all ones, everything else zero.
  function automatic stats_t clear_stats();
    stats_t s;
    s = '0;
    s.duration_min = '1;
    s.sent_min     = '1;
    s.io_min       = '1;
    return s;
  endfunction

  // Saturating add for sums.
  function automatic sum_t sat_add_sum(sum_t a, sum_t b);
    logic [SUM_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
  endfunction

  // Saturating add for counts.
  function automatic count_t sat_add_count(count_t a, count_t b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  // Clip a merge value to the width of a count.
  function automatic count_t clip_count(value_t v);
    return (v[VALUE_WIDTH-1:COUNT_WIDTH] != '0) ? '1 : v[COUNT_WIDTH-1:0];
  endfunction

  // Clip a merge value to the width of a sample.
  function automatic sample_t clip_sample(value_t v);
    return (v[VALUE_WIDTH-1:SAMPLE_WIDTH] != '0) ? '1 : v[SAMPLE_WIDTH-1:0];
  endfunction

  // Clip a merge value to the width of a sum.
  function automatic sum_t clip_sum(value_t v);
    value_t top;
    top = value_t'({SUM_WIDTH{1'b1}});
    return (v > top) ? '1 : v[SUM_WIDTH-1:0];
  endfunction

endpackage

>>> src/csa_stats.sv
// Statistics register bank with its record, merge, read and clear update logic.
module csa_stats import csa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    apply,
  input  op_t     op,
  input  logic    threshold_enable,
  input  sample_t threshold_bytes,
  output value_t  read_value
);

  stats_t  stats;
  stats_t  stats_next;
  count_t  merge_count;
  sample_t merge_sample;
  sum_t    merge_sum;
  logic    large_send;

  // Merge values clipped to each statistic width.
  assign merge_count  = clip_count(op.stat_value);
  assign merge_sample = clip_sample(op.stat_value);
  assign merge_sum    = clip_sum(op.stat_value);

  // A send at or above the threshold counts as large when counting is on.
  assign large_send = threshold_enable && (op.send_size >= threshold_bytes);

  // Next value of the statistics for the item in the update stage.
  always_comb begin
    stats_next = stats;
    if (apply) begin
      unique case (op.command)
        CMD_RECORD: begin
          stats_next.event_count = sat_add_count(stats.event_count, count_t'(1));
          stats_next.duration_sum =
            sat_add_sum(stats.duration_sum, sum_t'(op.duration));
          stats_next.duration_square_sum =
            sat_add_sum(stats.duration_square_sum, op.duration_square);
          if (op.duration > stats.duration_max) stats_next.duration_max = op.duration;
          if (op.duration < stats.duration_min) stats_next.duration_min = op.duration;
          stats_next.sent_sum = sat_add_sum(stats.sent_sum, sum_t'(op.send_size));
          if (op.send_size > stats.sent_max) stats_next.sent_max = op.send_size;
          if (op.send_size < stats.sent_min) stats_next.sent_min = op.send_size;
          stats_next.io_sum = sat_add_sum(stats.io_sum, sum_t'(op.io_size));
          if (op.io_size > stats.io_max) stats_next.io_max = op.io_size;
          if (op.io_size < stats.io_min) stats_next.io_min = op.io_size;
          stats_next.rma_sum = sat_add_sum(stats.rma_sum, sum_t'(op.rma_size));
          if (large_send) begin
            stats_next.large_message_count =
              sat_add_count(stats.large_message_count, count_t'(1));
          end
        end
        CMD_MERGE: begin
          unique case (op.stat_index)
            STAT_EVENT_COUNT: begin
              stats_next.event_count = sat_add_count(stats.event_count, merge_count);
            end
            STAT_DURATION_SUM: begin
              stats_next.duration_sum = sat_add_sum(stats.duration_sum, merge_sum);
            end
            STAT_DURATION_SQ: begin
              stats_next.duration_square_sum =
                sat_add_sum(stats.duration_square_sum, merge_sum);
            end
            STAT_DURATION_MAX: begin
              if (merge_sample > stats.duration_max) stats_next.duration_max = merge_sample;
            end
            STAT_DURATION_MIN: begin
              if (merge_sample < stats.duration_min) stats_next.duration_min = merge_sample;
            end
            STAT_SENT_SUM: begin
              stats_next.sent_sum = sat_add_sum(stats.sent_sum, merge_sum);
            end
            STAT_SENT_MAX: begin
              if (merge_sample > stats.sent_max) stats_next.sent_max = merge_sample;
            end
            STAT_SENT_MIN: begin
              if (merge_sample < stats.sent_min) stats_next.sent_min = merge_sample;
            end
            STAT_IO_SUM: begin
              stats_next.io_sum = sat_add_sum(stats.io_sum, merge_sum);
            end
            STAT_IO_MAX: begin
              if (merge_sample > stats.io_max) stats_next.io_max = merge_sample;
            end
            STAT_IO_MIN: begin
              if (merge_sample < stats.io_min) stats_next.io_min = merge_sample;
            end
            STAT_RMA_SUM: begin
              stats_next.rma_sum = sat_add_sum(stats.rma_sum, merge_sum);
            end
            STAT_LARGE_COUNT: begin
              stats_next.large_message_count =
                sat_add_count(stats.large_message_count, merge_count);
            end
            default: begin
              stats_next = stats;
            end
          endcase
        end
        CMD_READ: begin
          stats_next = stats;
        end
        CMD_CLEAR: begin
          stats_next = clear_stats();
        end
      endcase
    end
  end

  // Statistics registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= clear_stats();
    end else begin
      stats <= stats_next;
    end
  end

  // Read selection; unknown indexes read as zero.
  always_comb begin
    unique case (op.stat_index)
      STAT_EVENT_COUNT:  read_value = value_t'(stats.event_count);
      STAT_DURATION_SUM: read_value = value_t'(stats.duration_sum);
      STAT_DURATION_SQ:  read_value = value_t'(stats.duration_square_sum);
      STAT_DURATION_MAX: read_value = value_t'(stats.duration_max);
      STAT_DURATION_MIN: read_value = value_t'(stats.duration_min);
      STAT_SENT_SUM:     read_value = value_t'(stats.sent_sum);
      STAT_SENT_MAX:     read_value = value_t'(stats.sent_max);
      STAT_SENT_MIN:     read_value = value_t'(stats.sent_min);
      STAT_IO_SUM:       read_value = value_t'(stats.io_sum);
      STAT_IO_MAX:       read_value = value_t'(stats.io_max);
      STAT_IO_MIN:       read_value = value_t'(stats.io_min);
      STAT_RMA_SUM:      read_value = value_t'(stats.rma_sum);
      STAT_LARGE_COUNT:  read_value = value_t'(stats.large_message_count);
      default:           read_value = '0;
    endcase
  end

endmodule

>>> src/call_statistics_accumulator_top.sv
// Top level of the call statistics accumulator: handshakes, pipeline and config.
//
//   Channel  Direction  Handshake              Payload
//   cmd      in         cmd_valid / cmd_stall  command, duration, send_size, io_size,
//                                              rma_size, stat_index, stat_value
//   rd       out        rd_valid / rd_stall    read_index, read_value
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle is accepted while cmd_stall is low. An item is held in the input
// register, where the duration square is already formed, and is applied to the
// statistics as it moves on; a read result is loaded into the output register then.
// Synchronous reset clears the statistics, the configuration and both valid flags.
// A stalled read result holds only a read waiting behind it; other commands flow on.
module call_statistics_accumulator_top import csa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [31:0] duration,
  input  logic [31:0] send_size,
  input  logic [31:0] io_size,
  input  logic [31:0] rma_size,
  input  logic [3:0]  stat_index,
  input  logic [63:0] stat_value,
  output logic        rd_valid,
  input  logic        rd_stall,
  output logic [3:0]  read_index,
  output logic [63:0] read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic    op_valid;
  op_t     op;
  logic    op_is_read;
  logic    advance;
  logic    accept;
  logic    threshold_enable;
  sample_t threshold_bytes;
  value_t  stat_read;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_enable <= 1'b0;
      threshold_bytes  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD_ENABLE: threshold_enable <= cfg_data[0];
        CFG_THRESHOLD_BYTES:  threshold_bytes  <= cfg_data;
      endcase
    end
  end

  // The held item moves on unless it is a read and the result register is blocked.
  assign op_is_read = (op.command == CMD_READ);
  assign advance    = op_valid && !(op_is_read && rd_valid && rd_stall);
  assign cmd_stall  = op_valid && !advance;
  assign accept     = cmd_valid && !cmd_stall;

  // Input register; the duration square is formed on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (accept) begin
      op_valid <= 1'b1;
    end else if (advance) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op.command         <= cmd_t'(command);
      op.duration        <= duration;
      op.send_size       <= send_size;
      op.io_size         <= io_size;
      op.rma_size        <= rma_size;
      op.duration_square <= sum_t'(64'(duration) * 64'(duration));
      op.stat_index      <= stat_idx_t'(stat_index);
      op.stat_value      <= stat_value;
    end
  end

  csa_stats u_stats (
    .clk              (clk),
    .rst              (rst),
    .apply            (advance),
    .op               (op),
    .threshold_enable (threshold_enable),
    .threshold_bytes  (threshold_bytes),
    .read_value       (stat_read)
  );

  // Result register for read items.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (advance && op_is_read) begin
      rd_valid <= 1'b1;
    end else if (!rd_stall) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && op_is_read) begin
      read_index <= op.stat_index;
      read_value <= stat_read;
    end
  end

endmodule
